@@ sv/tet_pkg.sv @@
// ----------------------------------------------------------------------------
// tet_pkg: shared types and constants for the token expiry table
// Operation codes, the default table depth and reset ttl, the front/back word type and the engine states.
// ----------------------------------------------------------------------------
package tet_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam logic [31:0] TTL_RESET = 32'd5;

	localparam logic [1:0] OP_GENERATE = 2'd0;
	localparam logic [1:0] OP_RENEW    = 2'd1;
	localparam logic [1:0] OP_COUNT    = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] token_key;
		logic [31:0] current_time;
	} tet_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_COUNT,
		ST_DONE
	} tet_state_t;

endpackage

@@ sv/token_expiry_table.sv @@
// Token expiry table.
// Generate/renew words pass a match scan, one write and a count scan in the
// table engine; count-only words take the count scan alone.
// One word in the table engine at a time; a new one is taken only once the
// previous result has left the output register. Two-entry queue in front.
// Reset clears all entry valid bits at once and sets time_to_live to 5.
// ----------------------------------------------------------------------------
// token_expiry_table: top level
// Front queue plus table engine with key and stamp RAMs.
// ----------------------------------------------------------------------------
module token_expiry_table
	import tet_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] token_key,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  unexpired_count,
	output logic        table_full
);

	logic     cmd_valid, cmd_take;
	tet_cmd_t cmd;

	tet_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .token_key(token_key), .current_time(current_time),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	tet_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.out_valid(out_valid), .out_ready(out_ready),
		.unexpired_count(unexpired_count), .table_full(table_full)
	);

endmodule

@@ sv/tet_ram.sv @@
// ----------------------------------------------------------------------------
// tet_ram: generic single-port RAM
// One address a cycle, optional write, registered read data (old contents on a write).
// ----------------------------------------------------------------------------
module tet_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ sv/tet_front.sv @@
// ----------------------------------------------------------------------------
// tet_front: input stage and command queue
// Accepts words, folds unused operation codes into count, queues two deep.
// ----------------------------------------------------------------------------
module tet_front
	import tet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] token_key,
	input  logic [31:0] current_time,
	output logic        cmd_valid,
	input  logic        cmd_take,
	output tet_cmd_t    cmd
);

	tet_cmd_t   slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	tet_cmd_t   in_cmd;
	logic       push, pop;

	always_comb begin
		in_cmd.operation    = (operation == OP_GENERATE || operation == OP_RENEW)
			? operation : OP_COUNT;
		in_cmd.token_key    = token_key;
		in_cmd.current_time = current_time;
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_take;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/tet_back.sv @@
// ----------------------------------------------------------------------------
// tet_back: table engine
// Scans the table for key match and first free slot, updates at most one entry,
// then rescans to count live entries; count words only do the count scan. Result sits in an output register.
// ----------------------------------------------------------------------------
module tet_back
	import tet_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        cmd_valid,
	output logic        cmd_take,
	input  tet_cmd_t    cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  unexpired_count,
	output logic        table_full
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = ($clog2(TABLE_ENTRIES + 1) > 7) ?
		$clog2(TABLE_ENTRIES + 1) : 8;
	localparam logic [AW:0] LAST = (AW+1)'(TABLE_ENTRIES - 1);

	tet_state_t state_q, state_d;
	logic [31:0] ttl_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	tet_cmd_t cmd_q;
	logic [AW:0] idx_q;            // address issued this cycle
	logic [AW-1:0] rd_idx_q;       // address whose data arrives now
	logic rd_vld_q;
	logic match_q, free_q;
	logic [AW-1:0] match_idx_q, free_idx_q;
	logic [CW-1:0] cnt_q;
	logic out_valid_q, full_q;
	logic [6:0] count_out_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [63:0] key_rd;
	logic [31:0] stamp_rd, stamp_wd;
	logic live, key_hit;

	tet_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_key_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cmd_q.token_key), .rdata(key_rd)
	);
	tet_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_stamp_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(stamp_wd), .rdata(stamp_rd)
	);

	assign stamp_wd = cmd_q.current_time;
	assign live     = valid_q[rd_idx_q] && ((cmd_q.current_time - stamp_rd) < ttl_q);
	assign key_hit  = valid_q[rd_idx_q] && (key_rd == cmd_q.token_key);

	assign out_valid       = out_valid_q;
	assign unexpired_count = count_out_q;
	assign table_full      = full_q;

	// write target: matching key wins, else first free slot (generate only)
	logic do_write;
	logic [AW-1:0] wr_idx;
	always_comb begin
		wr_idx = match_q ? match_idx_q : free_idx_q;
		case (cmd_q.operation)
			OP_GENERATE: do_write = match_q || free_q;
			OP_RENEW:    do_write = match_q;  // match_live folded into match_q for renew
			default:     do_write = 1'b0;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		cmd_take = 1'b0;
		ram_we   = 1'b0;
		ram_addr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					cmd_take = 1'b1;
					state_d  = (cmd.operation == OP_COUNT) ? ST_COUNT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q > LAST) state_d = rd_vld_q ? ST_SCAN : ST_WRITE;
			end
			ST_WRITE: begin
				ram_addr = wr_idx;
				ram_we   = do_write;
				state_d  = ST_COUNT;
			end
			ST_COUNT: begin
				if (idx_q > LAST && !rd_vld_q) state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ttl_q       <= TTL_RESET;
			valid_q     <= '0;
			idx_q       <= '0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			match_idx_q <= '0;
			free_idx_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			full_q      <= 1'b0;
			count_out_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) ttl_q <= cfg_wdata;
			out_valid_q <= (state_q == ST_DONE) || (out_valid_q && !out_ready);
			rd_vld_q <= (state_q == ST_SCAN || state_q == ST_COUNT) && (idx_q <= LAST);
			case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					match_q <= 1'b0;
					free_q  <= 1'b0;
					cnt_q   <= '0;
				end
				ST_SCAN, ST_COUNT: begin
					if (idx_q <= LAST) begin
						rd_idx_q <= idx_q[AW-1:0];
						idx_q    <= idx_q + 1'b1;
					end
					if (rd_vld_q) begin
						if (state_q == ST_SCAN) begin
							// renew only accepts a match that is still live
							if (key_hit && !match_q &&
								(cmd_q.operation == OP_GENERATE || live)) begin
								match_q     <= 1'b1;
								match_idx_q <= rd_idx_q;
							end
							if (!live && !free_q) begin
								free_q     <= 1'b1;
								free_idx_q <= rd_idx_q;
							end
						end else if (live) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_WRITE: begin
					idx_q <= '0;
					if (do_write) valid_q[wr_idx] <= 1'b1;
					full_q <= (cmd_q.operation == OP_GENERATE) && !do_write;
				end
				ST_DONE: begin
					count_out_q <= (cnt_q > CW'(127)) ? 7'd127 : cnt_q[6:0];
					if (cmd_q.operation == OP_COUNT) full_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ tb/sv/tb_token_expiry_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_token_expiry_table: self-checking bench for the token expiry table
// Drives generate/renew/count words with random gaps and output stalls and
// checks every result word against a local table model kept in a class.
// ----------------------------------------------------------------------------
module tb_token_expiry_table;
	import tet_pkg::*;

	localparam int NSLOT = 64;
	localparam int QUIET_LIMIT = 20000;

	class ttl_scoreboard;
		logic        slot_used [NSLOT];
		logic [63:0] slot_key  [NSLOT];
		logic [31:0] slot_stamp[NSLOT];
		logic [31:0] ttl;
		logic [6:0]  count_q[$];
		logic        full_q[$];
		int          n_err;
		int          n_checked;
		int          n_full;

		function void clear();
			for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
			ttl = TTL_RESET;
		endfunction

		function bit live(int i, logic [31:0] now);
			logic [31:0] age;
			age = now - slot_stamp[i];
			return slot_used[i] && (age < ttl);
		endfunction

		function int lookup(logic [63:0] key);
			for (int i = 0; i < NSLOT; i++)
				if (slot_used[i] && slot_key[i] == key) return i;
			return -1;
		endfunction

		function void note_word(logic [1:0] op, logic [63:0] key, logic [31:0] now);
			int slot;
			logic full;
			int cnt;
			full = 1'b0;
			cnt = 0;
			if (op == OP_GENERATE) begin
				slot = lookup(key);
				if (slot < 0)
					for (int i = 0; i < NSLOT; i++)
						if (!live(i, now)) begin
							slot = i;
							break;
						end
				if (slot < 0) full = 1'b1;
				else begin
					slot_used[slot] = 1'b1;
					slot_key[slot] = key;
					slot_stamp[slot] = now;
				end
			end else if (op == OP_RENEW) begin
				slot = lookup(key);
				if (slot >= 0 && live(slot, now)) slot_stamp[slot] = now;
			end
			for (int i = 0; i < NSLOT; i++) if (live(i, now)) cnt++;
			if (cnt > 127) cnt = 127;
			count_q.push_back(cnt[6:0]);
			full_q.push_back(full);
			if (full) n_full++;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
			n_err++;
		endtask

		task check_word(logic [6:0] cnt, logic full);
			n_checked++;
			if (count_q.size() == 0) begin
				report("unexpected word", 32'(cnt), 32'd0);
				return;
			end
			if (cnt !== count_q[0]) report("unexpired_count", 32'(cnt), 32'(count_q[0]));
			if (full !== full_q[0]) report("table_full", 32'(full), 32'(full_q[0]));
			void'(count_q.pop_front());
			void'(full_q.pop_front());
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [63:0] token_key;
	logic [31:0] current_time;
	logic        out_valid;
	logic        out_ready;
	logic [6:0]  unexpired_count;
	logic        table_full;

	ttl_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	int quiet_cycles;
	logic [31:0] now_t;
	logic [63:0] key_pool[8];

	token_expiry_table u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.token_key(token_key), .current_time(current_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.unexpired_count(unexpired_count), .table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_word(unexpired_count, table_full);
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved in %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// valid stays up between back-to-back words; idle gaps and drain drop it
	task send_word(logic [1:0] op, logic [63:0] key, logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		token_key <= key;
		current_time <= t;
		do @(posedge clk); while (!in_ready);
		sb.note_word(op, key, t);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.count_q.size() != 0) @(posedge clk);
		// every sent word has been checked; idle margin before the next phase
		repeat (2 * NSLOT + 20) @(posedge clk);
	endtask

	task write_ttl(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.ttl = v;
	endtask

	// mostly well-formed traffic: small key pool, slowly advancing time
	task random_phase(int n, int idle, int stall);
		logic [1:0] op;
		logic [63:0] key;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			op = 2'($urandom_range(3));
			if ($urandom_range(9) < 8)
				key = key_pool[$urandom_range(7)] + 64'($urandom_range(79));
			else key = {$urandom, $urandom};
			if ($urandom_range(3) == 0) now_t = now_t + $urandom_range(3);
			else if ($urandom_range(49) == 0) now_t = now_t + $urandom;
			send_word(op, key, now_t);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = OP_COUNT;
		token_key = '0;
		current_time = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset ttl, extremes, renew of missing and expired, op three
		send_word(OP_COUNT, 64'd0, 32'd0);
		send_word(OP_RENEW, 64'd7, 32'd0);
		send_word(OP_GENERATE, 64'd0, 32'd0);
		send_word(OP_GENERATE, '1, 32'd1);
		send_word(OP_GENERATE, 64'd0, 32'd2);
		send_word(OP_RENEW, '1, 32'd4);
		send_word(2'd3, '1, 32'd6);
		send_word(OP_RENEW, 64'd0, 32'd7);
		send_word(OP_RENEW, 64'd0, 32'd8);
		send_word(OP_GENERATE, 64'h5555_5555_5555_5555, '1);
		send_word(OP_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		send_word(OP_COUNT, 64'd0, 32'd1);
		drain();

		// fill the table past its depth with a huge ttl to force drops
		write_ttl('1);
		now_t = 32'd100;
		for (int i = 0; i < NSLOT + 4; i++) send_word(OP_GENERATE, 64'd1000 + i, now_t);
		send_word(OP_GENERATE, 64'd1003, now_t + 1);
		drain();

		write_ttl(32'd0);
		send_word(OP_GENERATE, 64'd9, now_t);
		send_word(OP_COUNT, 64'd9, now_t);
		drain();
		write_ttl(32'd1);
		send_word(OP_GENERATE, 64'd2000, now_t);
		send_word(OP_RENEW, 64'd2000, now_t);
		send_word(OP_COUNT, 64'd0, now_t + 1);
		drain();

		write_ttl(32'd20);
		random_phase(500, 0, 0);
		drain();
		write_ttl(32'd200);
		random_phase(400, 86, 0);
		drain();
		write_ttl(32'd7);
		random_phase(400, 0, 86);
		drain();
		write_ttl(32'h8000_0000);
		random_phase(300, 34, 34);
		drain();

		// long receiver hold-off while the sender keeps offering
		write_ttl(32'd60);
		fork
			begin
				hold_off = 1'b1;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				random_phase(20, 0, 0);
				in_valid <= 1'b0;
				@(posedge clk);
			end
		join
		drain();
		write_ttl(32'd3);
		random_phase(300, 10, 10);
		drain();

		$display("covered %0d result words, %0d dropped generates, ttl from 0 to max",
			sb.n_checked, sb.n_full);
		if (sb.n_err == 0 && sb.count_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
